### rtl/core/frfc_pkg.sv
// ---------------------------------------------------------------------------
// frfc_pkg
// Shared types and constants for the fractional rate frame counter.
// ---------------------------------------------------------------------------
package frfc_pkg;

    // default widths of the frame position and the fraction accumulator
    localparam int FRAME_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 24;

    // field widths
    localparam int FUNC_W   = 2;
    localparam int TIME_W   = 20;
    localparam int RATE_W   = 16;
    localparam int COUNT_W  = 16;
    localparam int TARGET_W = 16;
    localparam int STEP_W   = 17;
    localparam int OUT_W    = 16;
    localparam int CFG_W    = 16;

    // fraction bits of delta_time times frame_rate (Q3.16 times Q8.8)
    localparam int PRODUCT_FRAC = 24;

    // rate stored when zero is written, 30.0 frames per second in Q8.8
    localparam logic [RATE_W-1:0]  DEFAULT_RATE  = 16'd7680;
    localparam logic [COUNT_W-1:0] DEFAULT_COUNT = 16'd1;

    // register indexes
    localparam logic REG_FRAME_RATE  = 1'b0;
    localparam logic REG_FRAME_COUNT = 1'b1;

    // item functions
    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK = 2'd0,
        FUNC_PLAY = 2'd1,
        FUNC_SEEK = 2'd2,
        FUNC_STEP = 2'd3
    } t_func;

endpackage

### rtl/core/fractional_rate_frame_counter.sv
// ---------------------------------------------------------------------------
// fractional_rate_frame_counter
// Playback frame counter advanced by a Q8.8 frame rate through a fractional
// phase accumulator, with play/stop, seek and clamped step items.
// ---------------------------------------------------------------------------
// the input register and the result register form a two stage pipeline
// throughput: one item per cycle while the result side does not stall, and the
//   state updates as an item leaves stage one
// reset: synchronous active low; frame 0, fraction 0, stopped, rate 30.0 fps,
//   frame count 1, both stages empty
module fractional_rate_frame_counter
    import frfc_pkg::*;
#(
    parameter int FRAME_BITS    = FRAME_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration write port
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [CFG_W-1:0]           i_cfg_data,
    // input channel
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [FUNC_W-1:0]          i_func,
    input  logic signed [TIME_W-1:0]   i_delta_time,
    input  logic                       i_play_flag,
    input  logic [TARGET_W-1:0]        i_target_frame,
    input  logic signed [STEP_W-1:0]   i_step_amount,
    // result channel
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [OUT_W-1:0]           o_frame_now,
    output logic                       o_is_playing,
    output logic                       o_hit_end
);

    localparam int FB       = FRAME_BITS;
    localparam int XB       = FRACTION_BITS;
    localparam int TMAG_W   = TIME_W - 1;
    localparam int PROD_W   = TMAG_W + RATE_W;
    localparam int SHL      = (XB >= PRODUCT_FRAC) ? XB - PRODUCT_FRAC : 0;
    localparam int SHR      = (XB < PRODUCT_FRAC) ? PRODUCT_FRAC - XB : 0;
    localparam int ALIGN_W  = PROD_W + SHL;
    localparam int SUM_W    = ((ALIGN_W > XB) ? ALIGN_W : XB) + 1;
    localparam int ADV_W    = SUM_W - XB;
    localparam int POS_W    = ((FB > ADV_W) ? FB : ADV_W) + 1;
    localparam int TGT_CW   = (FB > TARGET_W) ? FB : TARGET_W;
    localparam int SW       = ((FB > STEP_W) ? FB : STEP_W) + 2;
    localparam int LAST_W   = 33;

    // configuration registers
    logic [RATE_W-1:0]         r_frame_rate;
    logic [COUNT_W-1:0]        r_frame_count;

    // state
    logic [FB-1:0]             r_pos;
    logic [XB-1:0]             r_frac;
    logic                      r_play;
    logic [FB-1:0]             n_pos;
    logic [XB-1:0]             n_frac;
    logic                      n_play;
    logic                      n_hit;

    // input stage
    logic                      r_in_valid;
    t_func                     r_in_func;
    logic signed [TIME_W-1:0]  r_in_time;
    logic                      r_in_flag;
    logic [TARGET_W-1:0]       r_in_target;
    logic signed [STEP_W-1:0]  r_in_step;

    // result stage
    logic                      r_out_valid;
    logic [OUT_W-1:0]          r_frame_now;
    logic                      r_is_playing;
    logic                      r_hit_end;

    // handshake
    logic                      out_free;
    logic                      in_free;
    logic                      advance;

    // datapath
    logic [LAST_W-1:0]         count_m1;
    logic [FB-1:0]             last;
    logic [FB-1:0]             pos_cl;
    logic [TMAG_W-1:0]         t_mag;
    logic [PROD_W-1:0]         product;
    logic [ALIGN_W-1:0]        aligned;
    logic [SUM_W-1:0]          sum;
    logic [ADV_W-1:0]          adv;
    logic [POS_W-1:0]          adv_pos;
    logic [TGT_CW-1:0]         tgt_cmp;
    logic [TGT_CW-1:0]         last_cmp;
    logic [FB-1:0]             seek_pos;
    logic signed [SW-1:0]      step_sum;
    logic signed [SW-1:0]      last_s;
    logic [FB-1:0]             step_pos;

    // pipeline flow
    assign out_free = !r_out_valid || !i_stall;
    assign in_free  = !r_in_valid || out_free;
    assign advance  = r_in_valid && out_free;
    assign o_stall  = !in_free;

    // configuration writes, zero maps to the defaults
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_rate  <= DEFAULT_RATE;
            r_frame_count <= DEFAULT_COUNT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FRAME_RATE: begin
                    r_frame_rate <= (i_cfg_data == '0) ? DEFAULT_RATE : i_cfg_data;
                end
                REG_FRAME_COUNT: begin
                    r_frame_count <= (i_cfg_data == '0) ? DEFAULT_COUNT : i_cfg_data;
                end
                default: begin
                    r_frame_rate <= r_frame_rate;
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_valid) begin
            r_in_func   <= t_func'(i_func);
            r_in_time   <= i_delta_time;
            r_in_flag   <= i_play_flag;
            r_in_target <= i_target_frame;
            r_in_step   <= i_step_amount;
        end
    end

    // last frame and clamp of the current frame
    assign count_m1 = LAST_W'(r_frame_count) - LAST_W'(1);
    assign last     = count_m1[FB-1:0];
    assign pos_cl   = (r_pos > last) ? last : r_pos;

    // phase accumulator: negative time counts as zero
    assign t_mag   = r_in_time[TIME_W-1] ? '0 : r_in_time[TMAG_W-1:0];
    assign product = PROD_W'(t_mag) * PROD_W'(r_frame_rate);
    assign aligned = (ALIGN_W'(product) << SHL) >> SHR;
    assign sum     = SUM_W'(r_frac) + SUM_W'(aligned);
    assign adv     = sum[SUM_W-1:XB];
    assign adv_pos = POS_W'(pos_cl) + POS_W'(adv);

    // seek target clamp
    assign tgt_cmp  = TGT_CW'(r_in_target);
    assign last_cmp = TGT_CW'(last);
    assign seek_pos = (tgt_cmp > last_cmp) ? last : tgt_cmp[FB-1:0];

    // signed step with clamp to zero and last frame
    assign step_sum = $signed({{(SW-FB){1'b0}}, pos_cl}) + SW'(r_in_step);
    assign last_s   = $signed({{(SW-FB){1'b0}}, last});
    always_comb begin
        if (step_sum < 0) begin
            step_pos = '0;
        end else if (step_sum > last_s) begin
            step_pos = last;
        end else begin
            step_pos = step_sum[FB-1:0];
        end
    end

    // next state for the item in the input stage
    always_comb begin
        n_pos  = pos_cl;
        n_frac = r_frac;
        n_play = r_play;
        n_hit  = 1'b0;
        unique case (r_in_func)
            FUNC_TICK: begin
                if (r_play) begin
                    n_frac = sum[XB-1:0];
                    if (adv != '0) begin
                        if (adv_pos >= POS_W'(last)) begin
                            n_pos  = last;
                            n_play = 1'b0;
                            n_frac = '0;
                            n_hit  = 1'b1;
                        end else begin
                            n_pos = adv_pos[FB-1:0];
                        end
                    end
                end
            end
            FUNC_PLAY: begin
                n_play = r_in_flag;
                if (!r_in_flag) begin
                    n_frac = '0;
                end
            end
            FUNC_SEEK: begin
                n_pos  = seek_pos;
                n_frac = '0;
            end
            FUNC_STEP: begin
                n_pos  = step_pos;
                n_frac = '0;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_frac <= '0;
            r_play <= 1'b0;
        end else if (advance) begin
            r_pos  <= n_pos;
            r_frac <= n_frac;
            r_play <= n_play;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_frame_now  <= OUT_W'(n_pos);
            r_is_playing <= n_play;
            r_hit_end    <= n_hit;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_frame_now  = r_frame_now;
    assign o_is_playing = r_is_playing;
    assign o_hit_end    = r_hit_end;

`ifndef ASSERT_OFF
    // reaching the end always stops playback
    a_hit_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit_end) |-> !o_is_playing)
        else $error("hit_end with playback still running");

    // a seek or step leaves the fraction cleared
    a_seek_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_in_func == FUNC_SEEK || r_in_func == FUNC_STEP)) |=> (r_frac == '0))
        else $error("fraction not cleared after seek or step");

    // input stalls only while an item is held behind a blocked result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid && i_stall))
        else $error("input stalled without a held item");

    // an item leaving stage one always shows up as a result beat
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_valid)
        else $error("result beat missing after stage advance");
`endif

endmodule

### tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the fractional rate frame counter. A directed
// table walks register extremes, clamping, end of timeline and fraction
// carry; random phases follow, each with its own rate and frame count.
// Every accepted result beat is compared field by field against a typed
// row or the in-bench model, with random gaps and stalls on both sides.
// ---------------------------------------------------------------------------
module testbench;
    import frfc_pkg::*;

    localparam int PLAN_ROWS    = 31;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 125;

    // one input beat and one result beat
    typedef struct {
        t_func                      func;
        logic signed [TIME_W-1:0]   dt;
        logic                       flag;
        logic [TARGET_W-1:0]        target;
        logic signed [STEP_W-1:0]   step;
    } t_frame_cmd;

    typedef struct {
        logic [OUT_W-1:0]   frame;
        logic               playing;
        logic               hit;
    } t_frame_result;

    typedef enum bit {ROW_ITEM, ROW_WRITE} t_row_kind;

    typedef struct {
        t_row_kind          kind;
        logic               reg_sel;
        logic [CFG_W-1:0]   reg_value;
        t_frame_cmd         cmd;
        bit                 typed;
        t_frame_result      want;
    } t_plan_row;

    // directed table: typed results only where they are obvious
    t_plan_row plan [PLAN_ROWS] = '{
        '{ROW_ITEM,  0, 0, '{FUNC_TICK, 0, 0, 0, 0}, 1, '{0, 0, 0}},
        '{ROW_WRITE, REG_FRAME_COUNT, 0, '{FUNC_TICK, 0, 0, 0, 0}, 0, '{0, 0, 0}},
        '{ROW_ITEM,  0, 0, '{FUNC_STEP, 0, 0, 0, 65535}, 1, '{0, 0, 0}},
        '{ROW_WRITE, REG_FRAME_RATE, 0, '{FUNC_TICK, 0, 0, 0, 0}, 0, '{0, 0, 0}},
        '{ROW_WRITE, REG_FRAME_COUNT, 65535, '{FUNC_TICK, 0, 0, 0, 0}, 0, '{0, 0, 0}},
        '{ROW_ITEM,  0, 0, '{FUNC_SEEK, 0, 0, 65535, 0}, 1, '{65534, 0, 0}},
        '{ROW_ITEM,  0, 0, '{FUNC_SEEK, 0, 0, 0, 0}, 1, '{0, 0, 0}},
        '{ROW_ITEM,  0, 0, '{FUNC_STEP, 0, 0, 0, -65536}, 1, '{0, 0, 0}},
        '{ROW_ITEM,  0, 0, '{FUNC_STEP, 0, 0, 0, 65535}, 1, '{65534, 0, 0}},
        '{ROW_ITEM,  0, 0, '{FUNC_STEP, 0, 0, 0, -1}, 1, '{65533, 0, 0}},
        '{ROW_ITEM,  0, 0, '{FUNC_PLAY, 0, 1, 0, 0}, 1, '{65533, 1, 0}},
        '{ROW_ITEM,  0, 0, '{FUNC_TICK, -524288, 0, 0, 0}, 1, '{65533, 1, 0}},
        '{ROW_ITEM,  0, 0, '{FUNC_TICK, 524287, 0, 0, 0}, 1, '{65534, 0, 1}},
        '{ROW_ITEM,  0, 0, '{FUNC_SEEK, 0, 0, 100, 0}, 1, '{100, 0, 0}},
        '{ROW_ITEM,  0, 0, '{FUNC_PLAY, 0, 1, 0, 0}, 1, '{100, 1, 0}},
        '{ROW_ITEM,  0, 0, '{FUNC_TICK, 65536, 0, 0, 0}, 1, '{130, 1, 0}},
        '{ROW_ITEM,  0, 0, '{FUNC_TICK, 2048, 0, 0, 0}, 0, '{0, 0, 0}},
        '{ROW_ITEM,  0, 0, '{FUNC_TICK, 2048, 0, 0, 0}, 0, '{0, 0, 0}},
        '{ROW_ITEM,  0, 0, '{FUNC_PLAY, 0, 0, 0, 0}, 0, '{0, 0, 0}},
        '{ROW_ITEM,  0, 0, '{FUNC_TICK, 524287, 0, 0, 0}, 0, '{0, 0, 0}},
        '{ROW_WRITE, REG_FRAME_RATE, 65535, '{FUNC_TICK, 0, 0, 0, 0}, 0, '{0, 0, 0}},
        '{ROW_WRITE, REG_FRAME_COUNT, 120, '{FUNC_TICK, 0, 0, 0, 0}, 0, '{0, 0, 0}},
        '{ROW_ITEM,  0, 0, '{FUNC_PLAY, 0, 1, 0, 0}, 0, '{0, 0, 0}},
        '{ROW_ITEM,  0, 0, '{FUNC_TICK, 1, 0, 0, 0}, 0, '{0, 0, 0}},
        '{ROW_ITEM,  0, 0, '{FUNC_STEP, 0, 0, 0, -5}, 0, '{0, 0, 0}},
        '{ROW_ITEM,  0, 0, '{FUNC_TICK, 256, 0, 0, 0}, 0, '{0, 0, 0}},
        '{ROW_WRITE, REG_FRAME_COUNT, 2, '{FUNC_TICK, 0, 0, 0, 0}, 0, '{0, 0, 0}},
        '{ROW_WRITE, REG_FRAME_RATE, 1, '{FUNC_TICK, 0, 0, 0, 0}, 0, '{0, 0, 0}},
        '{ROW_ITEM,  0, 0, '{FUNC_PLAY, 0, 1, 0, 0}, 0, '{0, 0, 0}},
        '{ROW_ITEM,  0, 0, '{FUNC_TICK, 524287, 0, 0, 0}, 0, '{0, 0, 0}},
        '{ROW_ITEM,  0, 0, '{FUNC_SEEK, 0, 0, 1, 0}, 0, '{0, 0, 0}}
    };

    // bench signals
    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic                       cfg_index = 1'b0;
    logic [CFG_W-1:0]           cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    t_func                      func_sig = FUNC_TICK;
    logic signed [TIME_W-1:0]   delta_time = '0;
    logic                       play_flag = 1'b0;
    logic [TARGET_W-1:0]        target_frame = '0;
    logic signed [STEP_W-1:0]   step_amount = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [OUT_W-1:0]           frame_now;
    logic                       is_playing;
    logic                       hit_end;

    // model state of the counter
    logic [RATE_W-1:0]              rate_now = DEFAULT_RATE;
    logic [COUNT_W-1:0]             count_now = DEFAULT_COUNT;
    logic [OUT_W-1:0]               frame_pos = '0;
    logic [FRACTION_BITS_DEF-1:0]   phase_frac = '0;
    logic                           running = 1'b0;

    t_frame_result  pending_frames [$];
    int             error_count = 0;
    bit             quiet_phase = 1'b0;

    fractional_rate_frame_counter i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_valid        (in_valid),
        .o_stall        (in_stall),
        .i_func         (func_sig),
        .i_delta_time   (delta_time),
        .i_play_flag    (play_flag),
        .i_target_frame (target_frame),
        .i_step_amount  (step_amount),
        .o_valid        (out_valid),
        .i_stall        (out_stall),
        .o_frame_now    (frame_now),
        .o_is_playing   (is_playing),
        .o_hit_end      (hit_end)
    );

    // clock
    always begin
        #1 clk = 1'b1;
        #1 clk = 0;
    end

    // run limit
    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        error_count++;
    endtask

    function automatic int pick_wait();
        return quiet_phase ? 0 : $urandom_range(0, 11);
    endfunction

    // advance the model by one command, return the frame it reports
    // (fraction width equals the product's 24 fraction bits, so no shift)
    function automatic t_frame_result advance_frames(input t_frame_cmd cmd);
        logic [OUT_W-1:0]   last;
        logic [TIME_W-1:0]  t;
        logic [39:0]        sum;
        logic [15:0]        adv;
        longint             next_frame;
        t_frame_result      res;
        last = count_now - 1'b1;
        res.hit = 1'b0;
        // a shrunk timeline pulls the frame back first
        if (frame_pos > last)
            frame_pos = last;
        case (cmd.func)
            FUNC_TICK: begin
                if (running) begin
                    // negative time counts as zero
                    t = cmd.dt[TIME_W-1] ? '0 : cmd.dt;
                    sum = 40'(phase_frac) + 40'(t) * 40'(rate_now);
                    phase_frac = sum[FRACTION_BITS_DEF-1:0];
                    adv = sum[39:FRACTION_BITS_DEF];
                    if (adv != 0) begin
                        if (17'(frame_pos) + 17'(adv) >= 17'(last)) begin
                            frame_pos = last;
                            running = 1'b0;
                            phase_frac = '0;
                            res.hit = 1'b1;
                        end else begin
                            frame_pos = frame_pos + adv;
                        end
                    end
                end
            end
            FUNC_PLAY: begin
                running = cmd.flag;
                if (!cmd.flag)
                    phase_frac = '0;
            end
            FUNC_SEEK: begin
                frame_pos = (cmd.target > last) ? last : cmd.target;
                phase_frac = '0;
            end
            FUNC_STEP: begin
                next_frame = longint'(frame_pos) + longint'(cmd.step);
                if (next_frame < 0)
                    next_frame = 0;
                if (next_frame > longint'(last))
                    next_frame = longint'(last);
                frame_pos = next_frame[OUT_W-1:0];
                phase_frac = '0;
            end
        endcase
        res.frame = frame_pos;
        res.playing = running;
        return res;
    endfunction

    // random command, mostly well formed so playback runs for a while
    function automatic t_frame_cmd random_cmd();
        t_frame_cmd cmd;
        int sel;
        cmd.dt = TIME_W'($urandom);
        cmd.flag = 1'($urandom);
        cmd.target = TARGET_W'($urandom);
        cmd.step = STEP_W'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 50) begin
            cmd.func = FUNC_TICK;
            if ($urandom_range(0, 3) != 0)
                cmd.dt = TIME_W'($urandom_range(0, 32768));
        end else if (sel < 65) begin
            cmd.func = FUNC_PLAY;
            cmd.flag = ($urandom_range(0, 3) != 0);
        end else if (sel < 80) begin
            cmd.func = FUNC_SEEK;
            if ($urandom_range(0, 1) != 0)
                cmd.target = TARGET_W'($urandom_range(0, count_now));
        end else begin
            cmd.func = FUNC_STEP;
            if ($urandom_range(0, 1) != 0)
                cmd.step = STEP_W'(int'($urandom_range(0, 20)) - 10);
        end
        return cmd;
    endfunction

    // drive one input beat after a random gap, log its expected result
    task automatic send_beat(input t_frame_cmd cmd, input bit typed,
                             input t_frame_result typed_want);
        int gap;
        t_frame_result want;
        gap = pick_wait();
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        func_sig <= cmd.func;
        delta_time <= cmd.dt;
        play_flag <= cmd.flag;
        target_frame <= cmd.target;
        step_amount <= cmd.step;
        do @(posedge clk); while (in_stall);
        want = advance_frames(cmd);
        pending_frames.push_back(typed ? typed_want : want);
    endtask

    // register write once every pending result is back
    task automatic write_register(input logic sel, input logic [CFG_W-1:0] value);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= sel;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (sel == REG_FRAME_RATE)
            rate_now = (value == 0) ? DEFAULT_RATE : value;
        else
            count_now = (value == 0) ? DEFAULT_COUNT : value;
    endtask

    // result side stalls
    initial begin : result_backpressure
        int hold;
        forever begin
            hold = pick_wait();
            repeat (hold) begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // compare each result beat with the oldest expectation
    always @(posedge clk) begin : result_check
        t_frame_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_frames.size() == 0) begin
                report_mismatch($sformatf("unexpected beat, frame %0d", frame_now));
            end else begin
                want = pending_frames.pop_front();
                if (frame_now !== want.frame)
                    report_mismatch($sformatf("frame_now %0d, expected %0d",
                                              frame_now, want.frame));
                if (is_playing !== want.playing)
                    report_mismatch($sformatf("is_playing %0b, expected %0b",
                                              is_playing, want.playing));
                if (hit_end !== want.hit)
                    report_mismatch($sformatf("hit_end %0b, expected %0b",
                                              hit_end, want.hit));
            end
        end
    end

    // stimulus
    initial begin : stimulus
        logic [CFG_W-1:0] rate_pick;
        logic [CFG_W-1:0] count_pick;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int r = 0; r < PLAN_ROWS; r++) begin
            if (plan[r].kind == ROW_WRITE)
                write_register(plan[r].reg_sel, plan[r].reg_value);
            else
                send_beat(plan[r].cmd, plan[r].typed, plan[r].want);
        end

        // random phases, each opened by a drain and a new rate and count
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    rate_pick = 16'd65535;
                    count_pick = 16'd65535;
                end
                1: begin
                    rate_pick = 16'd1;
                    count_pick = 16'd2;
                end
                2: begin
                    rate_pick = 16'd0;
                    count_pick = 16'd0;
                end
                3: begin
                    rate_pick = DEFAULT_RATE;
                    count_pick = 16'd40;
                end
                default: begin
                    rate_pick = CFG_W'($urandom_range(1, 65535));
                    count_pick = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom)
                                                             : CFG_W'($urandom_range(1, 400));
                end
            endcase
            write_register(REG_FRAME_RATE, rate_pick);
            write_register(REG_FRAME_COUNT, count_pick);
            // some phases run with no gaps or stalls at all
            quiet_phase = (p % 3 == 2);
            repeat (PHASE_ITEMS) send_beat(random_cmd(), 1'b0, '{0, 0, 0});
        end

        // drain, then let the pipeline settle
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/core/frfc_pkg.sv
rtl/core/fractional_rate_frame_counter.sv
tb/testbench.sv
